@@ src/ydec_pkg.sv @@
// Shared types and constants for the yEnc stream decoder.
`default_nettype none
package ydec_pkg;

  // Configuration register indexes.
  localparam logic REG_MODE = 1'b0;

  // Decode modes held in the mode register.
  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_RAW   = 2'd1;
  localparam logic [1:0] MODE_END   = 2'd2;
  localparam logic [1:0] MODE_RESET = MODE_RAW;

  // Characters the decoder looks for.
  localparam logic [7:0] CH_EQ  = 8'h3D;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_Y   = 8'h79;

  // Offsets removed from ordinary and escaped bytes.
  localparam logic [7:0] OFS_PLAIN = 8'd42;
  localparam logic [7:0] OFS_ESC   = 8'd106;

  // Position of the decoder relative to line breaks.
  typedef enum logic [2:0] {
    TRK_MID   = 3'd0,
    TRK_CR    = 3'd1,
    TRK_CRLF  = 3'd2,
    TRK_DOT   = 3'd3,
    TRK_DOTCR = 3'd4,
    TRK_EQ    = 3'd5
  } ydec_trk_t;

  // One decoded result beat.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       end_found;
  } ydec_res_t;

endpackage
`default_nettype wire

@@ src/ydec_cfg.sv @@
// APB-style configuration register file holding the decode mode.
`default_nettype none
module ydec_cfg (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [1:0]       mode
);
  import ydec_pkg::*;

  logic [1:0] mode_r;
  logic [1:0] mode_nxt;
  logic       reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  // Register write decode; writes beyond the register list are dropped.
  always_comb begin
    mode_nxt = mode_r;
    if (wr_en && (reg_idx == REG_MODE)) begin
      mode_nxt = pwdata[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RESET;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  // Read back.
  assign prdata = (reg_idx == REG_MODE) ? {30'd0, mode_r} : 32'd0;
  assign mode   = mode_r;

endmodule
`default_nettype wire

@@ src/ydec_core.sv @@
// Per-byte decode logic with the escape, line and done state.
`default_nettype none
module ydec_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step,
  input  wire logic [7:0]         byte_in,
  input  wire logic [1:0]         mode,
  output ydec_pkg::ydec_res_t     res
);
  import ydec_pkg::*;

  logic      esc_r;
  logic      esc_nxt;
  ydec_trk_t trk_r;
  ydec_trk_t trk_nxt;
  logic      done_r;
  logic      done_nxt;
  ydec_trk_t trk;
  logic      raw;
  logic      endm;

  assign raw  = (mode != MODE_PLAIN);
  assign endm = mode[1];

  // Unused tracker codes count as mid line.
  always_comb begin
    case (trk_r)
      TRK_MID, TRK_CR, TRK_CRLF, TRK_DOT, TRK_DOTCR, TRK_EQ: trk = trk_r;
      default: trk = TRK_MID;
    endcase
  end

  // Decode one byte and work out the next state.
  always_comb begin
    res       = '0;
    esc_nxt   = esc_r;
    trk_nxt   = trk_r;
    done_nxt  = done_r;
    if (done_r) begin
      // The stream has ended; everything is ignored.
    end else if (esc_r) begin
      if ((trk == TRK_EQ) && endm && (byte_in == CH_Y)) begin
        res.end_found = 1'b1;
        done_nxt      = 1'b1;
      end else begin
        res.valid = 1'b1;
        res.data  = byte_in - OFS_ESC;
      end
      esc_nxt = 1'b0;
      trk_nxt = TRK_MID;
    end else if ((trk == TRK_DOTCR) && endm && (byte_in == CH_LF)) begin
      res.end_found = 1'b1;
      done_nxt      = 1'b1;
      trk_nxt       = TRK_MID;
    end else if ((trk == TRK_CRLF) && raw && (byte_in == CH_DOT)) begin
      trk_nxt = TRK_DOT;
    end else if (((trk == TRK_CRLF) || (trk == TRK_DOT)) && endm && (byte_in == CH_EQ)) begin
      esc_nxt = 1'b1;
      trk_nxt = TRK_EQ;
    end else if ((trk == TRK_DOT) && endm && (byte_in == CH_CR)) begin
      trk_nxt = TRK_DOTCR;
    end else if (byte_in == CH_LF) begin
      trk_nxt = ((trk == TRK_CR) || (trk == TRK_DOTCR)) ? TRK_CRLF : TRK_MID;
    end else if (byte_in == CH_CR) begin
      trk_nxt = TRK_CR;
    end else if (byte_in == CH_EQ) begin
      esc_nxt = 1'b1;
      trk_nxt = TRK_MID;
    end else begin
      res.valid = 1'b1;
      res.data  = byte_in - OFS_PLAIN;
      trk_nxt   = TRK_MID;
    end
  end

  // State advances only when a beat moves into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r  <= 1'b0;
      trk_r  <= TRK_CRLF;
      done_r <= 1'b0;
    end else if (step) begin
      esc_r  <= esc_nxt;
      trk_r  <= trk_nxt;
      done_r <= done_nxt;
    end
  end

  // Once ended, the stream stays ended until reset.
  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> done_r) else $error("stream done flag cleared");

  // Nothing is produced after the end.
  a_quiet_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    (step && done_r) |-> (!res.valid && !res.end_found))
    else $error("output after end of stream");

  // An end marker always sets the done flag.
  a_end_sets_done: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.end_found) |=> done_r) else $error("end seen but not recorded");

  // A terminator byte is never also data.
  a_end_not_data: assert property (@(posedge clk) disable iff (!rst_n)
    !(res.valid && res.end_found)) else $error("end marker carries data");

  // A pending escape only follows mid line or a line-start equals sign.
  a_esc_position: assert property (@(posedge clk) disable iff (!rst_n)
    (esc_r && !done_r) |-> ((trk_r == TRK_MID) || (trk_r == TRK_EQ)))
    else $error("escape pending at unexpected line position");

endmodule
`default_nettype wire

@@ src/yenc_stream_decoder.sv @@
// Top level of the yEnc stream decoder: handshake registers around the decode core.
//
//  Channel | Direction | Handshake            | Beat contents
//  in_     | input     | in_valid / in_stall  | in_byte
//  out_    | output    | out_vld / out_stall  | out_valid, out_byte, out_end_found
//  cfg_    | APB slave | psel, penable, ready | mode register at address 0
//
// One byte is accepted per cycle while in_stall is low. A byte taken into the input
// register is decoded out of it and lands in the result register, from which its result
// can be accepted on the output channel.
// Reset (rst_n low, synchronous) empties both registers and returns to line start.
// A stall on the output holds the result register and ripples back to in_stall
// only when the input register is also full.
`default_nettype none
module yenc_stream_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  output logic             out_vld,
  input  wire logic        out_stall,
  output logic             out_valid,
  output logic [7:0]       out_byte,
  output logic             out_end_found,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import ydec_pkg::*;

  logic       s1_vld_r;
  logic       s1_vld_nxt;
  logic [7:0] s1_byte_r;
  logic       o_vld_r;
  logic       o_vld_nxt;
  ydec_res_t  o_res_r;
  ydec_res_t  core_res;
  logic       adv_out;
  logic       adv_in;
  logic [1:0] mode;

  ydec_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .mode    (mode)
  );

  // Pipeline advance: each register moves when its successor has room.
  assign adv_out = !o_vld_r || !out_stall;
  assign adv_in  = !s1_vld_r || adv_out;
  assign in_stall = !adv_in;

  ydec_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (s1_vld_r && adv_out),
    .byte_in (s1_byte_r),
    .mode    (mode),
    .res     (core_res)
  );

  // Valid flags of the two registers.
  always_comb begin
    s1_vld_nxt = s1_vld_r;
    o_vld_nxt  = o_vld_r;
    if (adv_in) begin
      s1_vld_nxt = in_valid;
    end
    if (adv_out) begin
      o_vld_nxt = s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      o_vld_r  <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      o_vld_r  <= o_vld_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (adv_in) begin
      s1_byte_r <= in_byte;
    end
    if (adv_out) begin
      o_res_r <= core_res;
    end
  end

  assign out_vld       = o_vld_r;
  assign out_valid     = o_res_r.valid;
  assign out_byte      = o_res_r.data;
  assign out_end_found = o_res_r.end_found;

endmodule
`default_nettype wire
